/* hw/rtl/ssp_pkg.sv */
// ----------------------------------------------------------------------------
// Signature section parser package
// Shared types, result codes and sizing constants of the signature section
// parser.
// ----------------------------------------------------------------------------
package ssp_pkg;

  // Default length of one signed hash in bytes.
  localparam int unsigned DIGEST_BYTES_DEF = 32;

  // Unchecked header bytes at the start of the file.
  localparam int unsigned HEADER_BYTES = 8;
  // Length of the section name "signature".
  localparam int unsigned NAME_LEN = 9;
  // Longest ULEB128 encoding of a 32-bit value.
  localparam int unsigned LEB_MAX_BYTES = 5;

  // File offsets saturate at this value.
  localparam logic [32:0] POS_MAX = 33'h1_FFFF_FFFF;

  // Output queue of result pairs.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 2);

  // Stream widths.
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 144;
  localparam int unsigned OUT_TUSER_W = 4;

  // Result kinds.
  localparam logic [3:0] KIND_VERSION   = 4'd0;
  localparam logic [3:0] KIND_CONTENT   = 4'd1;
  localparam logic [3:0] KIND_HASH_FN   = 4'd2;
  localparam logic [3:0] KIND_HASH_BYTE = 4'd3;
  localparam logic [3:0] KIND_KEY_BYTE  = 4'd4;
  localparam logic [3:0] KIND_ALGORITHM = 4'd5;
  localparam logic [3:0] KIND_SIG_BYTE  = 4'd6;
  localparam logic [3:0] KIND_DONE      = 4'd7;
  localparam logic [3:0] KIND_ERROR     = 4'd8;

  // Error codes.
  localparam logic [3:0] ERR_NONE         = 4'd0;
  localparam logic [3:0] ERR_ENDED_EARLY  = 4'd1;
  localparam logic [3:0] ERR_NOT_CUSTOM   = 4'd2;
  localparam logic [3:0] ERR_BAD_LEB      = 4'd3;
  localparam logic [3:0] ERR_PAST_END     = 4'd4;
  localparam logic [3:0] ERR_WRONG_NAME   = 4'd5;
  localparam logic [3:0] ERR_VERSION      = 4'd6;
  localparam logic [3:0] ERR_CONTENT_TYPE = 4'd7;
  localparam logic [3:0] ERR_HASH_FN      = 4'd8;

  // One result word.
  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  payload;
    logic [31:0] block_number;
    logic [31:0] entry_number;
    logic [31:0] byte_position;
    logic [3:0]  error_code;
    logic [32:0] content_offset;
    logic        final_res;
  } result_t;

  // Results of one input byte: none, one, or two in order.
  typedef struct packed {
    logic    push;
    logic    two;
    result_t first;
    result_t second;
  } pair_t;

endpackage

/* hw/rtl/ssp_parser.sv */
// ----------------------------------------------------------------------------
// Signature section parse engine
// Walks the file one byte per valid cycle and produces the result words that
// the byte causes, at most two.
// ----------------------------------------------------------------------------
module ssp_parser #(
  parameter int unsigned DIGEST_BYTES = ssp_pkg::DIGEST_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    data_byte_i,
  input  logic          end_of_file_i,
  output ssp_pkg::pair_t emit_o
);
  import ssp_pkg::*;

  typedef enum logic [4:0] {
    PH_HDR, PH_ID, PH_SIZE, PH_NAMELEN, PH_NAME, PH_VER, PH_CT, PH_HF,
    PH_BLOCKS, PH_HCOUNT, PH_HASH, PH_SCOUNT, PH_KEYLEN, PH_KEY, PH_ALG,
    PH_SIGLEN, PH_SIG, PH_WAIT, PH_STOP
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [32:0] pos_q, pos_d;
  logic [32:0] sec_end_q, sec_end_d;
  logic [31:0] leb_val_q, leb_val_d;
  logic [2:0]  leb_cnt_q, leb_cnt_d;
  logic [31:0] blocks_left_q, blocks_left_d;
  logic [31:0] entries_left_q, entries_left_d;
  logic [31:0] field_left_q, field_left_d;
  logic [31:0] byte_pos_q, byte_pos_d;
  logic [31:0] block_idx_q, block_idx_d;
  logic [31:0] entry_idx_q, entry_idx_d;
  logic [3:0]  name_idx_q, name_idx_d;
  logic        bad_ver_q, bad_ver_d;
  logic        bad_ct_q, bad_ct_d;

  logic [32:0] next_pos;
  logic [31:0] leb_part;
  logic [31:0] leb_full;
  logic [33:0] len_end;
  logic [33:0] digest_end;
  logic        len_past;
  logic        digest_past;
  logic [32:0] size_end;
  logic        at_end;
  logic        byte_past;
  logic        item_ok;
  result_t     item_res;
  logic        term_ok;
  result_t     term_res;

  // Expected characters of the section name.
  function automatic logic [7:0] name_char(logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h73;
      4'd1:    c = 8'h69;
      4'd2:    c = 8'h67;
      4'd3:    c = 8'h6E;
      4'd4:    c = 8'h61;
      4'd5:    c = 8'h74;
      4'd6:    c = 8'h75;
      4'd7:    c = 8'h72;
      4'd8:    c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic result_t data_result(logic [3:0] kind, logic [7:0] b,
                                          logic [31:0] blk, logic [31:0] ent,
                                          logic [31:0] bpos);
    result_t r;
    r                = '0;
    r.kind           = kind;
    r.payload        = b;
    r.block_number   = blk;
    r.entry_number   = ent;
    r.byte_position  = bpos;
    r.error_code     = ERR_NONE;
    return r;
  endfunction

  function automatic result_t error_result(logic [3:0] code);
    result_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    r.final_res  = 1'b1;
    return r;
  endfunction

  function automatic result_t done_result(logic [32:0] off);
    result_t r;
    r                = '0;
    r.kind           = KIND_DONE;
    r.error_code     = ERR_NONE;
    r.content_offset = off;
    r.final_res      = 1'b1;
    return r;
  endfunction

  // Offset after this byte, saturating.
  assign next_pos = (pos_q == POS_MAX) ? POS_MAX : pos_q + 33'd1;

  // Seven value bits of this ULEB128 byte at their place; bits above 31 drop.
  always_comb begin
    case (leb_cnt_q)
      3'd0:    leb_part = {25'd0, data_byte_i[6:0]};
      3'd1:    leb_part = {18'd0, data_byte_i[6:0], 7'd0};
      3'd2:    leb_part = {11'd0, data_byte_i[6:0], 14'd0};
      3'd3:    leb_part = {4'd0, data_byte_i[6:0], 21'd0};
      3'd4:    leb_part = {data_byte_i[3:0], 28'd0};
      default: leb_part = '0;
    endcase
  end
  assign leb_full = leb_val_q | leb_part;

  // Bounds against the section end.
  assign len_end     = {1'b0, next_pos} + {2'b00, leb_full};
  assign len_past    = len_end > {1'b0, sec_end_q};
  assign size_end    = (len_end > {1'b0, POS_MAX}) ? POS_MAX : len_end[32:0];
  assign digest_end  = {1'b0, next_pos} + 34'(DIGEST_BYTES);
  assign digest_past = digest_end > {1'b0, sec_end_q};
  assign at_end      = next_pos >= sec_end_q;
  assign byte_past   = pos_q >= sec_end_q;

  // Next state and results of the byte at the input.
  always_comb begin
    phase_d        = phase_q;
    pos_d          = pos_q;
    sec_end_d      = sec_end_q;
    leb_val_d      = leb_val_q;
    leb_cnt_d      = leb_cnt_q;
    blocks_left_d  = blocks_left_q;
    entries_left_d = entries_left_q;
    field_left_d   = field_left_q;
    byte_pos_d     = byte_pos_q;
    block_idx_d    = block_idx_q;
    entry_idx_d    = entry_idx_q;
    name_idx_d     = name_idx_q;
    bad_ver_d      = bad_ver_q;
    bad_ct_d       = bad_ct_q;
    item_ok        = 1'b0;
    item_res       = '0;
    term_ok        = 1'b0;
    term_res       = '0;

    if (in_valid_i && phase_q != PH_STOP) begin
      pos_d = next_pos;
      unique case (phase_q)
        PH_HDR: begin
          if (next_pos >= 33'(HEADER_BYTES)) phase_d = PH_ID;
        end
        PH_ID: begin
          if (data_byte_i != 8'h00) begin
            term_ok  = 1'b1;
            term_res = error_result(ERR_NOT_CUSTOM);
          end else begin
            phase_d = PH_SIZE;
          end
        end
        PH_SIZE, PH_NAMELEN, PH_BLOCKS, PH_HCOUNT, PH_SCOUNT, PH_KEYLEN,
        PH_SIGLEN: begin
          if (leb_cnt_q >= 3'(LEB_MAX_BYTES)) begin
            term_ok  = 1'b1;
            term_res = error_result(ERR_BAD_LEB);
          end else if (data_byte_i[7]) begin
            leb_val_d = leb_full;
            leb_cnt_d = leb_cnt_q + 3'd1;
          end else begin
            // Value complete; the accumulator is left clear for the next one.
            leb_val_d = '0;
            leb_cnt_d = '0;
            case (phase_q)
              PH_SIZE: begin
                sec_end_d = size_end;
                phase_d   = PH_NAMELEN;
              end
              PH_NAMELEN: begin
                if (len_past) begin
                  term_ok  = 1'b1;
                  term_res = error_result(ERR_PAST_END);
                end else if (leb_full != 32'(NAME_LEN)) begin
                  term_ok  = 1'b1;
                  term_res = error_result(ERR_WRONG_NAME);
                end else begin
                  name_idx_d = '0;
                  phase_d    = PH_NAME;
                end
              end
              PH_BLOCKS: begin
                blocks_left_d = leb_full;
                block_idx_d   = '0;
                if (leb_full != '0) begin
                  phase_d = PH_HCOUNT;
                end else if (at_end) begin
                  term_ok  = 1'b1;
                  term_res = done_result(sec_end_q);
                end else begin
                  phase_d = PH_WAIT;
                end
              end
              PH_HCOUNT: begin
                entries_left_d = leb_full;
                entry_idx_d    = '0;
                if (leb_full == '0) begin
                  phase_d = PH_SCOUNT;
                end else if (digest_past) begin
                  term_ok  = 1'b1;
                  term_res = error_result(ERR_PAST_END);
                end else begin
                  field_left_d = 32'(DIGEST_BYTES);
                  byte_pos_d   = '0;
                  phase_d      = PH_HASH;
                end
              end
              PH_SCOUNT: begin
                entries_left_d = leb_full;
                entry_idx_d    = '0;
                if (leb_full != '0) begin
                  phase_d = PH_KEYLEN;
                end else begin
                  // Block without signatures closes at once.
                  blocks_left_d = blocks_left_q - 32'd1;
                  block_idx_d   = block_idx_q + 32'd1;
                  if (blocks_left_q != 32'd1) begin
                    phase_d = PH_HCOUNT;
                  end else if (at_end) begin
                    term_ok  = 1'b1;
                    term_res = done_result(sec_end_q);
                  end else begin
                    phase_d = PH_WAIT;
                  end
                end
              end
              PH_KEYLEN, PH_SIGLEN: begin
                if (len_past) begin
                  term_ok  = 1'b1;
                  term_res = error_result(ERR_PAST_END);
                end else if (leb_full != '0) begin
                  field_left_d = leb_full;
                  byte_pos_d   = '0;
                  phase_d      = (phase_q == PH_KEYLEN) ? PH_KEY : PH_SIG;
                end else if (phase_q == PH_KEYLEN) begin
                  phase_d = PH_ALG;
                end else begin
                  // Empty signature ends the record.
                  entries_left_d = entries_left_q - 32'd1;
                  entry_idx_d    = entry_idx_q + 32'd1;
                  if (entries_left_q != 32'd1) begin
                    phase_d = PH_KEYLEN;
                  end else begin
                    blocks_left_d = blocks_left_q - 32'd1;
                    block_idx_d   = block_idx_q + 32'd1;
                    if (blocks_left_q != 32'd1) begin
                      phase_d = PH_HCOUNT;
                    end else if (at_end) begin
                      term_ok  = 1'b1;
                      term_res = done_result(sec_end_q);
                    end else begin
                      phase_d = PH_WAIT;
                    end
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        PH_NAME: begin
          if (data_byte_i != name_char(name_idx_q)) begin
            term_ok  = 1'b1;
            term_res = error_result(ERR_WRONG_NAME);
          end else begin
            name_idx_d = name_idx_q + 4'd1;
            if (name_idx_q == 4'(NAME_LEN - 1)) phase_d = PH_VER;
          end
        end
        PH_VER, PH_CT: begin
          if (byte_past) begin
            term_ok  = 1'b1;
            term_res = error_result(ERR_PAST_END);
          end else if (phase_q == PH_VER) begin
            item_ok   = 1'b1;
            item_res  = data_result(KIND_VERSION, data_byte_i, '0, '0, '0);
            bad_ver_d = data_byte_i != 8'h01;
            phase_d   = PH_CT;
          end else begin
            item_ok  = 1'b1;
            item_res = data_result(KIND_CONTENT, data_byte_i, '0, '0, '0);
            bad_ct_d = data_byte_i != 8'h01;
            phase_d  = PH_HF;
          end
        end
        PH_HF: begin
          if (byte_past) begin
            term_ok  = 1'b1;
            term_res = error_result(ERR_PAST_END);
          end else begin
            item_ok  = 1'b1;
            item_res = data_result(KIND_HASH_FN, data_byte_i, '0, '0, '0);
            // The three header values are checked together, in order.
            if (bad_ver_q) begin
              term_ok  = 1'b1;
              term_res = error_result(ERR_VERSION);
            end else if (bad_ct_q) begin
              term_ok  = 1'b1;
              term_res = error_result(ERR_CONTENT_TYPE);
            end else if (data_byte_i != 8'h01) begin
              term_ok  = 1'b1;
              term_res = error_result(ERR_HASH_FN);
            end else begin
              phase_d = PH_BLOCKS;
            end
          end
        end
        PH_HASH: begin
          item_ok      = 1'b1;
          item_res     = data_result(KIND_HASH_BYTE, data_byte_i, block_idx_q,
                                     entry_idx_q, byte_pos_q);
          field_left_d = field_left_q - 32'd1;
          byte_pos_d   = byte_pos_q + 32'd1;
          if (field_left_q == 32'd1) begin
            entries_left_d = entries_left_q - 32'd1;
            entry_idx_d    = entry_idx_q + 32'd1;
            if (entries_left_q == 32'd1) begin
              phase_d = PH_SCOUNT;
            end else if (digest_past) begin
              term_ok  = 1'b1;
              term_res = error_result(ERR_PAST_END);
            end else begin
              field_left_d = 32'(DIGEST_BYTES);
              byte_pos_d   = '0;
            end
          end
        end
        PH_KEY: begin
          item_ok      = 1'b1;
          item_res     = data_result(KIND_KEY_BYTE, data_byte_i, block_idx_q,
                                     entry_idx_q, byte_pos_q);
          field_left_d = field_left_q - 32'd1;
          byte_pos_d   = byte_pos_q + 32'd1;
          if (field_left_q == 32'd1) phase_d = PH_ALG;
        end
        PH_ALG: begin
          if (byte_past) begin
            term_ok  = 1'b1;
            term_res = error_result(ERR_PAST_END);
          end else begin
            item_ok  = 1'b1;
            item_res = data_result(KIND_ALGORITHM, data_byte_i, block_idx_q,
                                   entry_idx_q, '0);
            phase_d  = PH_SIGLEN;
          end
        end
        PH_SIG: begin
          item_ok      = 1'b1;
          item_res     = data_result(KIND_SIG_BYTE, data_byte_i, block_idx_q,
                                     entry_idx_q, byte_pos_q);
          field_left_d = field_left_q - 32'd1;
          byte_pos_d   = byte_pos_q + 32'd1;
          if (field_left_q == 32'd1) begin
            // Last signature byte ends the record.
            entries_left_d = entries_left_q - 32'd1;
            entry_idx_d    = entry_idx_q + 32'd1;
            if (entries_left_q != 32'd1) begin
              phase_d = PH_KEYLEN;
            end else begin
              blocks_left_d = blocks_left_q - 32'd1;
              block_idx_d   = block_idx_q + 32'd1;
              if (blocks_left_q != 32'd1) begin
                phase_d = PH_HCOUNT;
              end else if (at_end) begin
                term_ok  = 1'b1;
                term_res = done_result(sec_end_q);
              end else begin
                phase_d = PH_WAIT;
              end
            end
          end
        end
        PH_WAIT: begin
          if (at_end) begin
            term_ok  = 1'b1;
            term_res = done_result(sec_end_q);
          end
        end
        default: begin
        end
      endcase
      if (term_ok) phase_d = PH_STOP;
    end

    // The last file byte ends any open parse and restarts the engine.
    if (in_valid_i && end_of_file_i) begin
      if (phase_q != PH_STOP && !term_ok) begin
        term_ok  = 1'b1;
        term_res = error_result(ERR_ENDED_EARLY);
      end
      phase_d        = PH_HDR;
      pos_d          = '0;
      sec_end_d      = '0;
      leb_val_d      = '0;
      leb_cnt_d      = '0;
      blocks_left_d  = '0;
      entries_left_d = '0;
      field_left_d   = '0;
      byte_pos_d     = '0;
      block_idx_d    = '0;
      entry_idx_d    = '0;
      name_idx_d     = '0;
      bad_ver_d      = 1'b0;
      bad_ct_d       = 1'b0;
    end
  end

  // Order the results: a data word always comes before a final word.
  always_comb begin
    emit_o.push   = item_ok | term_ok;
    emit_o.two    = item_ok & term_ok;
    emit_o.first  = item_ok ? item_res : term_res;
    emit_o.second = term_res;
  end

  // Parse state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HDR;
      pos_q          <= '0;
      sec_end_q      <= '0;
      leb_val_q      <= '0;
      leb_cnt_q      <= '0;
      blocks_left_q  <= '0;
      entries_left_q <= '0;
      field_left_q   <= '0;
      byte_pos_q     <= '0;
      block_idx_q    <= '0;
      entry_idx_q    <= '0;
      name_idx_q     <= '0;
      bad_ver_q      <= 1'b0;
      bad_ct_q       <= 1'b0;
    end else begin
      phase_q        <= phase_d;
      pos_q          <= pos_d;
      sec_end_q      <= sec_end_d;
      leb_val_q      <= leb_val_d;
      leb_cnt_q      <= leb_cnt_d;
      blocks_left_q  <= blocks_left_d;
      entries_left_q <= entries_left_d;
      field_left_q   <= field_left_d;
      byte_pos_q     <= byte_pos_d;
      block_idx_q    <= block_idx_d;
      entry_idx_q    <= entry_idx_d;
      name_idx_q     <= name_idx_d;
      bad_ver_q      <= bad_ver_d;
      bad_ct_q       <= bad_ct_d;
    end
  end

  // A pair of words always ends the parse with its second word.
  a_pair_ends_parse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o.push && emit_o.two) |-> emit_o.second.final_res)
    else $error("second word of a pair is not final");

  // A final word is never followed by another word of the same byte.
  a_final_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o.push && emit_o.first.final_res) |-> !emit_o.two)
    else $error("word after a final word");

  // The last file byte returns the engine to the header skip.
  a_eof_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && end_of_file_i) |=> (phase_q == PH_HDR))
    else $error("engine did not restart after end of file");

endmodule

/* hw/rtl/signature_section_parser_core.sv */
// ----------------------------------------------------------------------------
// Signature section parser core
// Streams the bytes of a module file and reports the fields of its signature
// custom section as tagged result words.
// ----------------------------------------------------------------------------
// One file byte is taken per cycle while s_axis_tready_o is high. A byte goes
// from the input register through the parse logic and its results, none,
// one or two, enter a four-entry queue of result pairs, from which they
// leave in order. A byte that causes two results sends them out one after
// the other, so input stalls only when the queue cannot take another pair,
// which the output side's tready and the number of two-result bytes decide.
module signature_section_parser_core #(
  parameter int unsigned DIGEST_BYTES = ssp_pkg::DIGEST_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input stream.
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [ssp_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,  // [7:0] data_byte
  input  logic                             s_axis_tlast_i,  // end_of_file
  // Result stream.
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [7:0] payload, [39:8] block_number, [71:40] entry_number,
  // [103:72] byte_position, [107:104] error_code, [140:108] content_offset,
  // [143:141] zero
  output logic [ssp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  output logic [ssp_pkg::OUT_TUSER_W-1:0]  m_axis_tuser_o,  // [3:0] kind
  output logic                             m_axis_tlast_o   // final_res
);
  import ssp_pkg::*;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_eof_q;
  logic        s_accept;

  pair_t       emit;

  pair_t              queue_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q;
  logic [QPTR_W-1:0]  rd_ptr_q;
  logic [QCNT_W-1:0]  count_q;
  logic               sel_q;
  logic               pop;
  logic               pop_entry;
  pair_t              head;
  result_t            out_res;

  // Room for the pair in flight and one more.
  assign s_axis_tready_o =
    (count_q + QCNT_W'(in_valid_q)) < QCNT_W'(QUEUE_DEPTH);
  assign s_accept = s_axis_tvalid_i & s_axis_tready_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= s_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q <= s_axis_tdata_i[7:0];
      in_eof_q  <= s_axis_tlast_i;
    end
  end

  ssp_parser #(
    .DIGEST_BYTES (DIGEST_BYTES)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_q),
    .data_byte_i   (in_byte_q),
    .end_of_file_i (in_eof_q),
    .emit_o        (emit)
  );

  // Result queue storage.
  always_ff @(posedge clk_i) begin
    if (emit.push) queue_mem[wr_ptr_q] <= emit;
  end

  // Head of the queue and the word selected from it.
  assign head      = queue_mem[rd_ptr_q];
  assign out_res   = sel_q ? head.second : head.first;
  assign pop       = m_axis_tvalid_o & m_axis_tready_i;
  assign pop_entry = pop & (sel_q | ~head.two);

  // Queue pointers and the word select within a pair.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      sel_q    <= 1'b0;
    end else begin
      if (emit.push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_entry) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (pop) sel_q <= ~pop_entry;
      case ({emit.push, pop_entry})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Output packing.
  assign m_axis_tvalid_o = count_q != '0;
  assign m_axis_tdata_o  = {3'b000, out_res.content_offset, out_res.error_code,
                            out_res.byte_position, out_res.entry_number,
                            out_res.block_number, out_res.payload};
  assign m_axis_tuser_o  = out_res.kind;
  assign m_axis_tlast_o  = out_res.final_res;

  // The queue always has room for a pair when one arrives.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.push |-> (count_q < QCNT_W'(QUEUE_DEPTH)))
    else $error("result queue overflow");

  // The second word is selected only while a pair is queued.
  a_sel_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> (count_q != '0))
    else $error("word select set on an empty queue");

  // The second word is selected only on a two-word pair.
  a_sel_needs_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> head.two)
    else $error("second word selected on a single-word entry");

endmodule

/* bench/signature_section_parser_core_tb.sv */
// ----------------------------------------------------------------------------
// Signature section parser core testbench
// Streams whole module files, most of them well formed with random content
// and the rest flawed in one way or another, into the parser. A predictor
// in the bench tracks the parse byte by byte and checks each result word in
// order. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module signature_section_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssp_pkg::*;

  localparam int unsigned DIGEST_LEN = DIGEST_BYTES_DEF;
  localparam logic [71:0] SECT_NAME = "signature";
  localparam int unsigned ITEM_TARGET = 900;

  // Phases of the predictor's walk through the file.
  typedef enum logic [4:0] {
    P_HEADER, P_ID, P_SIZE, P_NAMELEN, P_NAME, P_VERSION, P_CONTENT, P_HASHFN,
    P_BLOCKS, P_HCOUNT, P_HASH, P_SCOUNT, P_KEYLEN, P_KEY, P_ALG, P_SIGLEN,
    P_SIG, P_WAIT, P_STOP
  } phase_e;

  // Ways a generated file departs from a good one.
  typedef enum int {
    FL_NONE, FL_MUTATE, FL_TRUNC, FL_SHRINK, FL_NOISE, FL_NOT_CUSTOM,
    FL_BAD_LEB, FL_NAME_LEN, FL_NAME_BYTE, FL_VERSION, FL_CONTENT, FL_HASH_FN
  } flaw_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } file_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [IN_TDATA_W-1:0] s_data = '0;
  logic s_last = 1'b0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_data;
  logic [OUT_TUSER_W-1:0] m_user;
  logic m_last;

  file_byte_t file_bytes_q[$];
  result_t    results_due[$];
  logic [7:0] build_q[$];

  int mismatches = 0;
  int queued_bytes = 0;
  int send_gap = 0;
  int send_calm = 0;
  int recv_hold = 0;
  int recv_calm = 0;

  // Predictor state.
  phase_e      phase;
  logic [32:0] fpos;
  logic [32:0] sec_end;
  logic [31:0] leb_acc;
  int unsigned leb_sh;
  logic [31:0] blk_left;
  logic [31:0] ent_left;
  logic [31:0] fld_left;
  logic [31:0] fld_len;
  logic [31:0] blk_idx;
  logic [31:0] ent_idx;
  int unsigned name_idx;
  logic        halted;
  logic        ver_bad;
  logic        ct_bad;

  signature_section_parser_core #(
    .DIGEST_BYTES(DIGEST_LEN)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user),
    .m_axis_tlast_o (m_last)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic void clear_parser();
    phase = P_HEADER;
    fpos = '0;
    sec_end = '0;
    leb_acc = '0;
    leb_sh = 0;
    blk_left = '0;
    ent_left = '0;
    fld_left = '0;
    fld_len = '0;
    blk_idx = '0;
    ent_idx = '0;
    name_idx = 0;
    halted = 1'b0;
    ver_bad = 1'b0;
    ct_bad = 1'b0;
  endfunction

  function automatic void add_result(logic [3:0] kind, logic [7:0] pay, logic [31:0] blk,
                                     logic [31:0] ent, logic [31:0] pos, logic [3:0] err,
                                     logic [32:0] off, logic fin);
    result_t r;
    r.kind = kind;
    r.payload = pay;
    r.block_number = blk;
    r.entry_number = ent;
    r.byte_position = pos;
    r.error_code = err;
    r.content_offset = off;
    r.final_res = fin;
    results_due.insert(results_due.size(), r);
  endfunction

  function automatic void halt_with(logic [3:0] err);
    add_result(KIND_ERROR, '0, '0, '0, '0, err, '0, 1'b1);
    halted = 1'b1;
    phase = P_STOP;
  endfunction

  function automatic void leb_start(phase_e next);
    leb_acc = '0;
    leb_sh = 0;
    phase = next;
  endfunction

  // Done once the file has reached the section end, otherwise wait for it.
  function automatic void settle();
    if (fpos >= sec_end) begin
      add_result(KIND_DONE, '0, '0, '0, '0, ERR_NONE, sec_end, 1'b1);
      halted = 1'b1;
      phase = P_STOP;
    end else begin
      phase = P_WAIT;
    end
  endfunction

  function automatic void open_block();
    if (blk_left == 0) settle();
    else leb_start(P_HCOUNT);
  endfunction

  function automatic void open_hash();
    if (ent_left == 0) begin
      leb_start(P_SCOUNT);
    end else if ({1'b0, fpos} + 34'(DIGEST_LEN) > {1'b0, sec_end}) begin
      halt_with(ERR_PAST_END);
    end else begin
      fld_left = DIGEST_LEN;
      phase = P_HASH;
    end
  endfunction

  function automatic void open_record();
    if (ent_left == 0) begin
      blk_left--;
      blk_idx++;
      open_block();
    end else begin
      leb_start(P_KEYLEN);
    end
  endfunction

  function automatic void close_record();
    ent_left--;
    ent_idx++;
    open_record();
  endfunction

  function automatic logic past_end(logic [31:0] len);
    return {1'b0, fpos} + {2'b00, len} > {1'b0, sec_end};
  endfunction

  // A ULEB128 value is complete; act on it according to the field it ends.
  function automatic void leb_complete(logic [31:0] v);
    logic [33:0] e;
    case (phase)
      P_SIZE: begin
        e = {1'b0, fpos} + {2'b00, v};
        sec_end = (e > {1'b0, POS_MAX}) ? POS_MAX : e[32:0];
        leb_start(P_NAMELEN);
      end
      P_NAMELEN: begin
        if (past_end(v)) halt_with(ERR_PAST_END);
        else if (v != NAME_LEN) halt_with(ERR_WRONG_NAME);
        else begin
          name_idx = 0;
          phase = P_NAME;
        end
      end
      P_BLOCKS: begin
        blk_left = v;
        blk_idx = '0;
        open_block();
      end
      P_HCOUNT: begin
        ent_left = v;
        ent_idx = '0;
        open_hash();
      end
      P_SCOUNT: begin
        ent_left = v;
        ent_idx = '0;
        open_record();
      end
      P_KEYLEN: begin
        if (past_end(v)) halt_with(ERR_PAST_END);
        else if (v == 0) phase = P_ALG;
        else begin
          fld_len = v;
          fld_left = v;
          phase = P_KEY;
        end
      end
      P_SIGLEN: begin
        if (past_end(v)) halt_with(ERR_PAST_END);
        else if (v == 0) close_record();
        else begin
          fld_len = v;
          fld_left = v;
          phase = P_SIG;
        end
      end
      default: ;
    endcase
  endfunction

  // Walk one byte found at offset p.
  function automatic void walk_byte(logic [7:0] b, logic [32:0] p);
    case (phase)
      P_HEADER: if (fpos >= HEADER_BYTES) phase = P_ID;
      P_ID: begin
        if (b != 8'h00) halt_with(ERR_NOT_CUSTOM);
        else leb_start(P_SIZE);
      end
      P_SIZE, P_NAMELEN, P_BLOCKS, P_HCOUNT, P_SCOUNT, P_KEYLEN, P_SIGLEN: begin
        if (leb_sh >= 32) begin
          halt_with(ERR_BAD_LEB);
        end else begin
          // Bits shifted above bit 31 fall away.
          leb_acc |= {25'd0, b[6:0]} << leb_sh;
          leb_sh += 7;
          if (!b[7]) leb_complete(leb_acc);
        end
      end
      P_NAME: begin
        if (name_idx >= NAME_LEN || b != SECT_NAME[71-8*name_idx -: 8]) begin
          halt_with(ERR_WRONG_NAME);
        end else begin
          name_idx++;
          if (name_idx == NAME_LEN) phase = P_VERSION;
        end
      end
      P_VERSION: begin
        if (p >= sec_end) halt_with(ERR_PAST_END);
        else begin
          add_result(KIND_VERSION, b, '0, '0, '0, ERR_NONE, '0, 1'b0);
          ver_bad = (b != 8'h01);
          phase = P_CONTENT;
        end
      end
      P_CONTENT: begin
        if (p >= sec_end) halt_with(ERR_PAST_END);
        else begin
          add_result(KIND_CONTENT, b, '0, '0, '0, ERR_NONE, '0, 1'b0);
          ct_bad = (b != 8'h01);
          phase = P_HASHFN;
        end
      end
      P_HASHFN: begin
        if (p >= sec_end) halt_with(ERR_PAST_END);
        else begin
          add_result(KIND_HASH_FN, b, '0, '0, '0, ERR_NONE, '0, 1'b0);
          // Version is checked before content type, content type before hash fn.
          if (ver_bad) halt_with(ERR_VERSION);
          else if (ct_bad) halt_with(ERR_CONTENT_TYPE);
          else if (b != 8'h01) halt_with(ERR_HASH_FN);
          else leb_start(P_BLOCKS);
        end
      end
      P_HASH: begin
        add_result(KIND_HASH_BYTE, b, blk_idx, ent_idx, DIGEST_LEN - fld_left, ERR_NONE,
                   '0, 1'b0);
        fld_left--;
        if (fld_left == 0) begin
          ent_left--;
          ent_idx++;
          open_hash();
        end
      end
      P_KEY: begin
        add_result(KIND_KEY_BYTE, b, blk_idx, ent_idx, fld_len - fld_left, ERR_NONE,
                   '0, 1'b0);
        fld_left--;
        if (fld_left == 0) phase = P_ALG;
      end
      P_ALG: begin
        if (p >= sec_end) halt_with(ERR_PAST_END);
        else begin
          add_result(KIND_ALGORITHM, b, blk_idx, ent_idx, '0, ERR_NONE, '0, 1'b0);
          leb_start(P_SIGLEN);
        end
      end
      P_SIG: begin
        add_result(KIND_SIG_BYTE, b, blk_idx, ent_idx, fld_len - fld_left, ERR_NONE,
                   '0, 1'b0);
        fld_left--;
        if (fld_left == 0) close_record();
      end
      P_WAIT: if (fpos >= sec_end) settle();
      default: ;
    endcase
  endfunction

  // Predict the results of one accepted word.
  function automatic void track_byte(logic [7:0] b, logic eof);
    logic [32:0] p;
    if (!halted) begin
      p = fpos;
      fpos = (p < POS_MAX) ? p + 33'd1 : POS_MAX;
      walk_byte(b, p);
    end
    if (eof) begin
      if (!halted) halt_with(ERR_ENDED_EARLY);
      clear_parser();
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  // Idle length: mostly none or short, a few long, and calm stretches of none.
  function automatic int pick_idle(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm = $urandom_range(20, 60);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Append a ULEB128 value, sometimes padded to up to five bytes with junk in
  // the dropped bits of the fifth, rarely or on request one byte too long.
  function automatic void put_leb(logic [31:0] v, bit overlong);
    int nb;
    logic [7:0] b;
    nb = 1;
    while (nb < LEB_MAX_BYTES && (64'(v) >> (7 * nb)) != 0) nb++;
    if (overlong || $urandom_range(0, 199) == 0) nb = LEB_MAX_BYTES + 1;
    else if ($urandom_range(0, 99) < 15) nb = $urandom_range(nb, LEB_MAX_BYTES);
    for (int i = 0; i < nb; i++) begin
      b = 8'((64'(v) >> (7 * i)) & 64'h7F);
      if (i == 4) b[6:4] = 3'($urandom);
      if (i < nb - 1) b[7] = 1'b1;
      build_q.insert(build_q.size(), b);
    end
  endfunction

  function automatic logic [7:0] not_one();
    logic [7:0] v;
    v = 8'($urandom_range(0, 254));
    if (v >= 8'd1) v++;
    return v;
  endfunction

  function automatic void put_random(int n);
    repeat (n) build_q.insert(build_q.size(), 8'($urandom));
  endfunction

  // Build one module file and queue its words, the last one with tlast.
  task automatic make_file(input flaw_e flaw);
    logic [7:0] sect[$];
    logic [7:0] img[$];
    logic [7:0] c;
    logic [31:0] size;
    int nblk, nh, ns, len, bad_at, r, idx;
    file_byte_t fb;
    build_q = {};
    if (flaw == FL_NOISE) begin
      put_random($urandom_range(2, 30));
      img = build_q;
    end else begin
      // Section body, everything after the size field.
      if (flaw == FL_NAME_LEN) begin
        len = $urandom_range(0, 11);
        if (len >= NAME_LEN) len++;
        put_leb(len, 1'b0);
      end else begin
        put_leb(NAME_LEN, 1'b0);
      end
      bad_at = (flaw == FL_NAME_BYTE) ? $urandom_range(0, NAME_LEN - 1) : -1;
      for (int i = 0; i < NAME_LEN; i++) begin
        c = SECT_NAME[71-8*i -: 8];
        if (i == bad_at) c ^= 8'($urandom_range(1, 255));
        build_q.insert(build_q.size(), c);
      end
      build_q.insert(build_q.size(), flaw == FL_VERSION ? not_one() : 8'h01);
      build_q.insert(build_q.size(), flaw == FL_CONTENT ? not_one() : 8'h01);
      build_q.insert(build_q.size(), flaw == FL_HASH_FN ? not_one() : 8'h01);
      r = $urandom_range(0, 99);
      nblk = (r < 20) ? 0 : (r < 80) ? 1 : 2;
      put_leb(nblk, 1'b0);
      repeat (nblk) begin
        r = $urandom_range(0, 99);
        nh = (r < 55) ? 0 : (r < 92) ? 1 : 2;
        put_leb(nh, 1'b0);
        put_random(nh * DIGEST_LEN);
        ns = $urandom_range(0, 2);
        put_leb(ns, 1'b0);
        repeat (ns) begin
          len = $urandom_range(0, 3);
          put_leb(len, 1'b0);
          put_random(len);
          put_random(1);
          len = $urandom_range(0, 6);
          put_leb(len, 1'b0);
          put_random(len);
        end
      end
      // Bytes between the last record and the section end.
      put_random($urandom_range(0, 3));
      sect = build_q;
      size = sect.size();
      if (flaw == FL_SHRINK) size = $urandom_range(0, sect.size() - 1);

      // Header, section id and size, body, then some module content.
      build_q = {};
      put_random(HEADER_BYTES);
      build_q.insert(build_q.size(),
                     flaw == FL_NOT_CUSTOM ? 8'($urandom_range(1, 255)) : 8'h00);
      put_leb(size, flaw == FL_BAD_LEB);
      foreach (sect[i]) build_q.insert(build_q.size(), sect[i]);
      put_random($urandom_range(0, 4));
      img = build_q;
      if (flaw == FL_MUTATE) begin
        idx = $urandom_range(HEADER_BYTES, img.size() - 1);
        img[idx] = 8'($urandom);
      end else if (flaw == FL_TRUNC) begin
        len = $urandom_range(1, img.size() - 1);
        while (img.size() > len) void'(img.pop_back());
      end
    end
    foreach (img[i]) begin
      fb.data = img[i];
      fb.last = (i == img.size() - 1);
      file_bytes_q.insert(file_bytes_q.size(), fb);
    end
    queued_bytes += img.size();
  endtask

  // Hold off until every queued word is sent and every result has come.
  task automatic drain();
    while (file_bytes_q.size() != 0 || s_valid || results_due.size() != 0)
      @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i or negedge rst_ni) begin
    file_byte_t nxt;
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data <= '0;
      s_last <= 1'b0;
      send_gap = 0;
      clear_parser();
    end else if (!s_valid || s_ready) begin
      if (s_valid) track_byte(s_data, s_last);
      if (send_gap > 0) begin
        send_gap--;
        s_valid <= 1'b0;
      end else if (file_bytes_q.size() != 0) begin
        nxt = file_bytes_q.pop_front();
        s_valid <= 1'b1;
        s_data <= nxt.data;
        s_last <= nxt.last;
        send_gap = pick_idle(send_calm);
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      m_ready <= 1'b0;
      recv_hold = 0;
    end else begin
      if (m_valid && m_ready) begin
        got.kind = m_user;
        got.payload = m_data[7:0];
        got.block_number = m_data[39:8];
        got.entry_number = m_data[71:40];
        got.byte_position = m_data[103:72];
        got.error_code = m_data[107:104];
        got.content_offset = m_data[140:108];
        got.final_res = m_last;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: kind %0d payload %h error %0d",
                     got.kind, got.payload, got.error_code);
        end else begin
          want = results_due.pop_front();
          if (got.kind !== want.kind || got.payload !== want.payload ||
              got.block_number !== want.block_number ||
              got.entry_number !== want.entry_number ||
              got.byte_position !== want.byte_position ||
              got.error_code !== want.error_code ||
              got.content_offset !== want.content_offset ||
              got.final_res !== want.final_res) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch (expected/actual): kind %0d/%0d payload %h/%h",
                       want.kind, got.kind, want.payload, got.payload);
              $display("  block %0d/%0d entry %0d/%0d pos %0d/%0d",
                       want.block_number, got.block_number,
                       want.entry_number, got.entry_number,
                       want.byte_position, got.byte_position);
              $display("  error %0d/%0d offset %h/%h final %b/%b",
                       want.error_code, got.error_code,
                       want.content_offset, got.content_offset,
                       want.final_res, got.final_res);
            end
          end
        end
        recv_hold = pick_idle(recv_calm);
      end
      if (recv_hold > 0) begin
        recv_hold--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int files;
    int r;
    int guard;
    flaw_e flaw;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed files: good ones, each named error, and flawed layouts.
    make_file(FL_NONE);
    make_file(FL_NONE);
    make_file(FL_NOT_CUSTOM);
    make_file(FL_BAD_LEB);
    make_file(FL_NAME_LEN);
    make_file(FL_NAME_BYTE);
    make_file(FL_VERSION);
    make_file(FL_CONTENT);
    make_file(FL_HASH_FN);
    make_file(FL_SHRINK);
    make_file(FL_SHRINK);
    make_file(FL_SHRINK);
    make_file(FL_TRUNC);
    make_file(FL_NOISE);
    drain();

    // Random files, mostly well formed, with a full drain now and then.
    files = 0;
    while (queued_bytes < ITEM_TARGET) begin
      while (file_bytes_q.size() > 48) @(posedge clk_i);
      r = $urandom_range(0, 99);
      if (r < 60) flaw = FL_NONE;
      else if (r < 70) flaw = FL_MUTATE;
      else if (r < 78) flaw = FL_TRUNC;
      else if (r < 88) flaw = FL_SHRINK;
      else if (r < 92) flaw = FL_NOISE;
      else flaw = flaw_e'($urandom_range(FL_NOT_CUSTOM, FL_HASH_FN));
      make_file(flaw);
      files++;
      if (files % 8 == 0) drain();
    end

    while (file_bytes_q.size() != 0 || s_valid) @(posedge clk_i);
    guard = 0;
    while (results_due.size() != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
    if (results_due.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("signature_section_parser_core_tb: done, clean");
    end else begin
      $display("signature_section_parser_core_tb: done, errors");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #4ms;
    $display("signature_section_parser_core_tb: done, errors");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/ssp_pkg.sv
hw/rtl/ssp_parser.sv
hw/rtl/signature_section_parser_core.sv
bench/signature_section_parser_core_tb.sv
